// ===== rtl/tdc_pkg.sv =====
`timescale 1ns / 1ps

package tdc_pkg;

  localparam int REQ_W = 3;
  localparam int CNT_W = 32;
  localparam int BCD_W = 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK      = 3'd0,
    REQ_GET_TICKS = 3'd1,
    REQ_SET_TICKS = 3'd2,
    REQ_GET_TIME  = 3'd3,
    REQ_SET_TIME  = 3'd4
  } req_e;

  localparam logic [CNT_W-1:0] DAY_TICK_LIMIT = 32'h0018_00B2;

  // tick period 549254 / 10^7 s, reduced
  localparam int TICK_NUM = 274627;
  localparam int TICK_DEN = 5000000;

  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;

  // set time: ticks = floor(secs * TICK_DEN / TICK_NUM) by reciprocal
  localparam int SSECS_W    = 20;
  localparam int SET_K      = 39;
  localparam int SET_M_W    = 44;
  localparam int SET_M_LO_W = 22;
  localparam int SET_M_HI_W = SET_M_W - SET_M_LO_W;
  localparam logic [127:0] SET_M_FULL =
    (((128'd1 << SET_K) * 128'(TICK_DEN)) + 128'(TICK_NUM) - 128'd1) / 128'(TICK_NUM);
  localparam logic [SET_M_LO_W-1:0] SET_M_LO = SET_M_FULL[SET_M_LO_W-1:0];
  localparam logic [SET_M_HI_W-1:0] SET_M_HI = SET_M_FULL[SET_M_W-1:SET_M_LO_W];
  localparam int SPP_LO_W = SSECS_W + SET_M_LO_W;
  localparam int SPP_HI_W = SSECS_W + SET_M_HI_W;
  localparam int SSUM_W   = SSECS_W + SET_M_W;

  // get time: secs = floor(ticks * TICK_NUM / TICK_DEN) by reciprocal
  localparam int GET_K      = 55;
  localparam int GET_M_W    = 51;
  localparam int GET_M_LO_W = 25;
  localparam int GET_M_HI_W = GET_M_W - GET_M_LO_W;
  localparam logic [127:0] GET_M_FULL =
    (((128'd1 << GET_K) * 128'(TICK_NUM)) + 128'(TICK_DEN) - 128'd1) / 128'(TICK_DEN);
  localparam logic [GET_M_LO_W-1:0] GET_M_LO = GET_M_FULL[GET_M_LO_W-1:0];
  localparam logic [GET_M_HI_W-1:0] GET_M_HI = GET_M_FULL[GET_M_W-1:GET_M_LO_W];
  localparam int GPP_LO_W = CNT_W + GET_M_LO_W;
  localparam int GPP_HI_W = CNT_W + GET_M_HI_W;
  localparam int GSUM_W   = CNT_W + GET_M_W;
  localparam int GSECS_W  = 28;

  // hours = floor(secs / 3600)
  localparam int HR_K    = 40;
  localparam int HR_M_W  = 29;
  localparam logic [127:0] HR_M_FULL =
    ((128'd1 << HR_K) + 128'(SECS_PER_HOUR) - 128'd1) / 128'(SECS_PER_HOUR);
  localparam logic [HR_M_W-1:0] HR_M = HR_M_FULL[HR_M_W-1:0];
  localparam int HPROD_W = GSECS_W + HR_M_W;
  localparam int HRS_W   = 16;

  // minutes = floor(rem / 60)
  localparam int REM_W   = 12;
  localparam int MIN_K   = 18;
  localparam int MIN_M_W = 13;
  localparam logic [127:0] MIN_M_FULL =
    ((128'd1 << MIN_K) + 128'(SECS_PER_MIN) - 128'd1) / 128'(SECS_PER_MIN);
  localparam logic [MIN_M_W-1:0] MIN_M = MIN_M_FULL[MIN_M_W-1:0];
  localparam int MPROD_W = REM_W + MIN_M_W;
  localparam int MIN_W   = 6;

  // divide by ten for bcd, exact below 1029
  localparam int DIV10_K = 11;
  localparam logic [15:0] DIV10_M = 16'd205;

  // pipeline stages
  localparam int NUM_STAGES = 13;
  localparam int ST_IN    = 0;
  localparam int ST_SECS  = 1;
  localparam int ST_SPP   = 2;
  localparam int ST_SET   = 3;
  localparam int ST_STATE = 4;
  localparam int ST_GPP   = 5;
  localparam int ST_GSECS = 6;
  localparam int ST_HPROD = 7;
  localparam int ST_HRS   = 8;
  localparam int ST_REM   = 9;
  localparam int ST_MIN   = 10;
  localparam int ST_SEC   = 11;
  localparam int ST_OUT   = 12;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
    logic [NUM_STAGES-1:0] vld;
  } pipe_ctrl_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [CNT_W-1:0] ticks;
    logic [BCD_W-1:0] hour;
    logic [BCD_W-1:0] minute;
    logic [BCD_W-1:0] second;
  } req_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [CNT_W-1:0] ticks;
    logic [CNT_W-1:0] set_val;
  } set_rec_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [CNT_W-1:0] cnt;
    logic             roll;
  } cnt_rec_t;

  typedef struct packed {
    logic [CNT_W-1:0] tick_count;
    logic             rollover;
    logic [BCD_W-1:0] hour;
    logic [BCD_W-1:0] minute;
    logic [BCD_W-1:0] second;
  } rsp_t;

endpackage

// ===== rtl/tdc_req_if.sv =====
`timescale 1ns / 1ps

interface tdc_req_if import tdc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [CNT_W-1:0] ticks_in;
  logic [BCD_W-1:0] hour_bcd_in;
  logic [BCD_W-1:0] minute_bcd_in;
  logic [BCD_W-1:0] second_bcd_in;

  modport source (
    output valid, req_type, ticks_in, hour_bcd_in, minute_bcd_in, second_bcd_in,
    input  ready
  );

  modport sink (
    input  valid, req_type, ticks_in, hour_bcd_in, minute_bcd_in, second_bcd_in,
    output ready
  );
endinterface

// ===== rtl/tdc_rsp_if.sv =====
`timescale 1ns / 1ps

interface tdc_rsp_if import tdc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] tick_count;
  logic             rollover;
  logic [BCD_W-1:0] hour_bcd;
  logic [BCD_W-1:0] minute_bcd;
  logic [BCD_W-1:0] second_bcd;

  modport source (
    output valid, tick_count, rollover, hour_bcd, minute_bcd, second_bcd,
    input  ready
  );

  modport sink (
    input  valid, tick_count, rollover, hour_bcd, minute_bcd, second_bcd,
    output ready
  );
endinterface

// ===== rtl/tdc_set_conv.sv =====
`timescale 1ns / 1ps

module tdc_set_conv import tdc_pkg::*; (
  input  logic       clk_i,
  input  pipe_ctrl_t ctrl_i,
  input  req_t       req_i,
  output set_rec_t   rec_o
);

  function automatic logic [BCD_W-1:0] bcd_dec(input logic [BCD_W-1:0] b);
    logic [BCD_W-1:0] hi;
    logic [BCD_W-1:0] lo;
    hi = {4'd0, b[7:4]};
    lo = {4'd0, b[3:0]};
    return hi * 8'd10 + lo;
  endfunction

  req_t                  in_q;
  logic [REQ_W-1:0]      s1_req_q, s2_req_q;
  logic [CNT_W-1:0]      s1_ticks_q, s2_ticks_q;
  logic [SSECS_W-1:0]    secs_d, secs_q;
  logic [SPP_LO_W-1:0]   pp_lo_d, pp_lo_q;
  logic [SPP_HI_W-1:0]   pp_hi_d, pp_hi_q;
  logic [SSUM_W-1:0]     sum;
  set_rec_t              rec_d, rec_q;

  always_comb begin
    secs_d = SSECS_W'(bcd_dec(in_q.hour)) * SSECS_W'(SECS_PER_HOUR)
           + SSECS_W'(bcd_dec(in_q.minute)) * SSECS_W'(SECS_PER_MIN)
           + SSECS_W'(bcd_dec(in_q.second));
  end

  assign pp_lo_d = SPP_LO_W'(secs_q) * SPP_LO_W'(SET_M_LO);
  assign pp_hi_d = SPP_HI_W'(secs_q) * SPP_HI_W'(SET_M_HI);

  always_comb begin
    sum = (SSUM_W'(pp_hi_q) << SET_M_LO_W) + SSUM_W'(pp_lo_q);
    rec_d.req_type = s2_req_q;
    rec_d.ticks    = s2_ticks_q;
    rec_d.set_val  = CNT_W'(sum >> SET_K);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[ST_IN]) begin
      in_q <= req_i;
    end
    if (ctrl_i.en[ST_SECS]) begin
      s1_req_q   <= in_q.req_type;
      s1_ticks_q <= in_q.ticks;
      secs_q     <= secs_d;
    end
    if (ctrl_i.en[ST_SPP]) begin
      s2_req_q   <= s1_req_q;
      s2_ticks_q <= s1_ticks_q;
      pp_lo_q    <= pp_lo_d;
      pp_hi_q    <= pp_hi_d;
    end
    if (ctrl_i.en[ST_SET]) begin
      rec_q <= rec_d;
    end
  end

  assign rec_o = rec_q;

endmodule

// ===== rtl/tdc_state.sv =====
`timescale 1ns / 1ps

module tdc_state import tdc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  pipe_ctrl_t ctrl_i,
  input  set_rec_t   rec_i,
  output cnt_rec_t   rec_o
);

  logic [CNT_W-1:0] day_d, day_q;
  logic             flag_d, flag_q;
  logic [CNT_W-1:0] day_inc;
  logic             roll;
  logic             upd;
  cnt_rec_t         rec_q;

  assign upd     = ctrl_i.vld[ST_SET] && ctrl_i.en[ST_STATE];
  assign day_inc = day_q + 32'd1;

  always_comb begin
    day_d  = day_q;
    flag_d = flag_q;
    roll   = flag_q;
    case (rec_i.req_type)
      REQ_TICK: begin
        // all-ones count wraps to zero without the flag
        if (day_inc >= DAY_TICK_LIMIT) begin
          day_d  = '0;
          flag_d = 1'b1;
          roll   = 1'b1;
        end else begin
          day_d = day_inc;
        end
      end
      REQ_GET_TICKS: begin
        flag_d = 1'b0;
      end
      REQ_SET_TICKS: begin
        day_d  = rec_i.ticks;
        flag_d = 1'b0;
        roll   = 1'b0;
      end
      REQ_SET_TIME: begin
        day_d = rec_i.set_val;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      day_q  <= '0;
      flag_q <= 1'b0;
    end else if (upd) begin
      day_q  <= day_d;
      flag_q <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[ST_STATE]) begin
      rec_q.req_type <= rec_i.req_type;
      rec_q.cnt      <= day_d;
      rec_q.roll     <= roll;
    end
  end

  assign rec_o = rec_q;

  a_set_ticks_clears_flag: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    upd && rec_i.req_type == REQ_SET_TICKS |=> !flag_q && !rec_q.roll
  ) else $error("set ticks left the midnight flag set");

  a_get_ticks_reports_flag: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    upd && rec_i.req_type == REQ_GET_TICKS |=> rec_q.roll == $past(flag_q) && !flag_q
  ) else $error("get ticks did not report then clear the flag");

  a_tick_below_limit: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    upd && rec_i.req_type == REQ_TICK |=> day_q < DAY_TICK_LIMIT && rec_q.cnt == day_q
  ) else $error("tick left the count at or above the rollover point");

  a_state_only_on_update: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !upd |=> $stable(day_q) && $stable(flag_q)
  ) else $error("state changed without a transaction in the state stage");

endmodule

// ===== rtl/tdc_get_conv.sv =====
`timescale 1ns / 1ps

module tdc_get_conv import tdc_pkg::*; (
  input  logic       clk_i,
  input  pipe_ctrl_t ctrl_i,
  input  cnt_rec_t   rec_i,
  output rsp_t       rsp_o
);

  function automatic logic [BCD_W-1:0] to_bcd8(input logic [BCD_W-1:0] v);
    logic [15:0]      p;
    logic [4:0]       q;
    logic [BCD_W-1:0] r;
    p = 16'(v) * DIV10_M;
    q = p[DIV10_K+4:DIV10_K];
    r = v - 8'(q) * 8'd10;
    return {q[3:0], r[3:0]};
  endfunction

  cnt_rec_t              r5_q, r6_q, r7_q, r8_q, r9_q, r10_q, r11_q;
  logic [GPP_LO_W-1:0]   gpp_lo_q;
  logic [GPP_HI_W-1:0]   gpp_hi_q;
  logic [GSUM_W-1:0]     gsum;
  logic [GSECS_W-1:0]    secs6_q, secs7_q, secs8_q;
  logic [HPROD_W-1:0]    hprod_q;
  logic [HRS_W-1:0]      hrs_q;
  logic [GSECS_W-1:0]    rem_full;
  logic [REM_W-1:0]      rem9_q, rem10_q;
  logic [BCD_W-1:0]      hr9_q, hr10_q, hr11_q;
  logic [MPROD_W-1:0]    mprod;
  logic [MIN_W-1:0]      min10_q, min11_q;
  logic [REM_W-1:0]      sec_full;
  logic [MIN_W-1:0]      sec11_q;
  rsp_t                  rsp_d, rsp_q;

  assign gsum     = (GSUM_W'(gpp_hi_q) << GET_M_LO_W) + GSUM_W'(gpp_lo_q);
  assign rem_full = secs8_q - GSECS_W'(hrs_q) * GSECS_W'(SECS_PER_HOUR);
  assign mprod    = MPROD_W'(rem9_q) * MPROD_W'(MIN_M);
  assign sec_full = rem10_q - REM_W'(min10_q) * REM_W'(SECS_PER_MIN);

  always_comb begin
    rsp_d.tick_count = r11_q.cnt;
    rsp_d.rollover   = r11_q.roll;
    rsp_d.hour       = '0;
    rsp_d.minute     = '0;
    rsp_d.second     = '0;
    if (r11_q.req_type == REQ_GET_TIME) begin
      rsp_d.hour   = to_bcd8(hr11_q);
      rsp_d.minute = to_bcd8(BCD_W'(min11_q));
      rsp_d.second = to_bcd8(BCD_W'(sec11_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[ST_GPP]) begin
      r5_q     <= rec_i;
      gpp_lo_q <= GPP_LO_W'(rec_i.cnt) * GPP_LO_W'(GET_M_LO);
      gpp_hi_q <= GPP_HI_W'(rec_i.cnt) * GPP_HI_W'(GET_M_HI);
    end
    if (ctrl_i.en[ST_GSECS]) begin
      r6_q    <= r5_q;
      secs6_q <= gsum[GET_K+GSECS_W-1:GET_K];
    end
    if (ctrl_i.en[ST_HPROD]) begin
      r7_q    <= r6_q;
      secs7_q <= secs6_q;
      hprod_q <= HPROD_W'(secs6_q) * HPROD_W'(HR_M);
    end
    if (ctrl_i.en[ST_HRS]) begin
      r8_q    <= r7_q;
      secs8_q <= secs7_q;
      hrs_q   <= hprod_q[HR_K+HRS_W-1:HR_K];
    end
    if (ctrl_i.en[ST_REM]) begin
      r9_q   <= r8_q;
      hr9_q  <= hrs_q[BCD_W-1:0];
      rem9_q <= rem_full[REM_W-1:0];
    end
    if (ctrl_i.en[ST_MIN]) begin
      r10_q   <= r9_q;
      hr10_q  <= hr9_q;
      rem10_q <= rem9_q;
      min10_q <= mprod[MIN_K+MIN_W-1:MIN_K];
    end
    if (ctrl_i.en[ST_SEC]) begin
      r11_q   <= r10_q;
      hr11_q  <= hr10_q;
      min11_q <= min10_q;
      sec11_q <= sec_full[MIN_W-1:0];
    end
    if (ctrl_i.en[ST_OUT]) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

// ===== rtl/bios_daily_tick_clock.sv =====
`timescale 1ns / 1ps
// throughput: one request per cycle through a 13-stage pipeline unless it is full
//   and the sink stalls; the conversions by constant reciprocals are split over
//   partial-product and sum stages
// each full stage holds when its successor is full and stalled; bubbles squeeze out
// reset: tick count and midnight flag clear to zero, all stages empty

module bios_daily_tick_clock import tdc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  tdc_req_if.sink          req_i,
  tdc_rsp_if.source        rsp_o
);

  logic [NUM_STAGES-1:0] vld_d, vld_q;
  logic [NUM_STAGES-1:0] en;
  pipe_ctrl_t            ctrl;
  req_t                  req;
  set_rec_t              set_rec;
  cnt_rec_t              cnt_rec;
  rsp_t                  rsp;

  // a stage may load when it or any stage after it is empty, or the sink takes
  always_comb begin
    for (int i = 0; i < NUM_STAGES; i++) begin
      en[i] = rsp_o.ready || (((~vld_q) >> i) != '0);
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = req_i.valid;
    end
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (en[i]) begin
        vld_d[i] = vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign ctrl.en  = en;
  assign ctrl.vld = vld_q;

  assign req.req_type = req_i.req_type;
  assign req.ticks    = req_i.ticks_in;
  assign req.hour     = req_i.hour_bcd_in;
  assign req.minute   = req_i.minute_bcd_in;
  assign req.second   = req_i.second_bcd_in;

  assign req_i.ready = en[ST_IN];

  tdc_set_conv u_set_conv (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .req_i  (req),
    .rec_o  (set_rec)
  );

  tdc_state u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .rec_i  (set_rec),
    .rec_o  (cnt_rec)
  );

  tdc_get_conv u_get_conv (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .rec_i  (cnt_rec),
    .rsp_o  (rsp)
  );

  assign rsp_o.valid      = vld_q[ST_OUT];
  assign rsp_o.tick_count = rsp.tick_count;
  assign rsp_o.rollover   = rsp.rollover;
  assign rsp_o.hour_bcd   = rsp.hour;
  assign rsp_o.minute_bcd = rsp.minute;
  assign rsp_o.second_bcd = rsp.second;

endmodule
